// ===== src/psg_pkg.sv =====
// ---------------------------------------------------------------------------
// psg_pkg: shared definitions for the population spike generator
// Widths, population size, configuration register map and the state
// memory word and write port types.
// ---------------------------------------------------------------------------
package psg_pkg;

  localparam int POPULATION = 256;
  localparam int ADDR_W     = $clog2(POPULATION);
  localparam int NEURON_W   = 8;
  localparam int PHASE_W    = 16;
  localparam int RATE_W     = 31;
  localparam int COUNT_W    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int MUL_W      = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GEN_MODE         = 3'd0,
    CFG_EDGE_OR_LEVEL    = 3'd1,
    CFG_START_PHASE      = 3'd2,
    CFG_TICK_SECONDS     = 3'd3,
    CFG_TICKS_PER_SECOND = 3'd4,
    CFG_DEFAULT_RATE     = 3'd5,
    CFG_USE_RATE_INPUT   = 3'd6
  } cfg_idx_t;

  localparam logic GEN_REGULAR   = 1'b0;
  localparam logic GEN_TRIGGERED = 1'b1;
  localparam logic TRIG_EDGE     = 1'b0;
  localparam logic TRIG_LEVEL    = 1'b1;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic               trig;
  } psg_word_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    psg_word_t         word;
  } psg_wr_t;

endpackage

// ===== src/psg_if.sv =====
// ---------------------------------------------------------------------------
// psg_if: tick and result channels
// Valid/ready channels carrying one neuron tick word and one result word.
// ---------------------------------------------------------------------------
interface psg_tick_if;
  logic               valid;
  logic               ready;
  logic [7:0]         neuron;
  logic signed [31:0] rate_hz;
  logic               trigger_high;
  logic               trigger_wired;
  logic               enabled;
  logic               reset_request;

  modport source (
    output valid, neuron, rate_hz, trigger_high, trigger_wired, enabled, reset_request,
    input  ready
  );
  modport sink (
    input  valid, neuron, rate_hz, trigger_high, trigger_wired, enabled, reset_request,
    output ready
  );
endinterface

interface psg_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  neuron_out;
  logic        spike;
  logic [7:0]  spike_total;
  logic [30:0] firing_rate_hz;
  logic [30:0] effective_rate_hz;

  modport source (
    output valid, neuron_out, spike, spike_total, firing_rate_hz, effective_rate_hz,
    input  ready
  );
  modport sink (
    input  valid, neuron_out, spike, spike_total, firing_rate_hz, effective_rate_hz,
    output ready
  );
endinterface

// ===== src/psg_mul.sv =====
// ---------------------------------------------------------------------------
// psg_mul: shared unsigned multiplier
// 32 x 32 unsigned multiply with a registered 64-bit product.
// ---------------------------------------------------------------------------
module psg_mul (
  input  logic                            clk,
  input  logic [psg_pkg::MUL_W-1:0]       a,
  input  logic [psg_pkg::MUL_W-1:0]       b,
  output logic [2*psg_pkg::MUL_W-1:0]     p
);
  import psg_pkg::*;

  always_ff @(posedge clk) begin
    p <= {{MUL_W{1'b0}}, a} * {{MUL_W{1'b0}}, b};
  end

endmodule

// ===== src/psg_state_mem.sv =====
// ---------------------------------------------------------------------------
// psg_state_mem: per-neuron phase and trigger memory
// One read and one write port, registered read data; entries not yet
// written since reset read as zero through per-entry valid bits.
// ---------------------------------------------------------------------------
module psg_state_mem (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        rd_en,
  input  logic [psg_pkg::ADDR_W-1:0]  rd_addr,
  output psg_pkg::psg_word_t          rd_word,
  input  psg_pkg::psg_wr_t            wr
);
  import psg_pkg::*;

  psg_word_t              mem [POPULATION];
  logic [POPULATION-1:0]  valid;
  psg_word_t              rd_q;
  logic                   rd_hit;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.word;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_hit <= 1'b0;
    end else begin
      if (wr.en) begin
        valid[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit <= valid[rd_addr];
      end
    end
  end

  assign rd_word = rd_hit ? rd_q : '0;

endmodule

// ===== src/population_spike_generator.sv =====
// ---------------------------------------------------------------------------
// population_spike_generator: phase-accumulator spike train generator
// Serves a bank of neurons, one tick word at a time, through a shared
// multiplier under a small sequencer.
//
// tick: valid/ready input, one word per neuron tick (index, rate, trigger,
//   enable, reset request). ready is high only while the sequencer is idle.
// result: valid/ready output, one word per tick word, held in an output
//   register until taken.
// cfg: write enable, register index and data, written while idle.
// After a tick word is accepted, the steps are the read, the rate multiply,
//   the phase update with count multiply, and the saturate and load.
// The next tick word waits until the sequencer is idle, held off by the two
//   passes through the shared multiplier and the phase memory read-modify-write.
// A stalled result holds the sequencer in its last step; the next tick
//   word is taken as soon as that result is loaded into the output register.
// Reset: configuration returns to its defaults, all phases and trigger bits
//   read as zero, no result pending. No clearing pass is needed.
// ---------------------------------------------------------------------------
module population_spike_generator (
  input  logic                            clk,
  input  logic                            rst,
  psg_tick_if.sink                        tick,
  psg_result_if.source                    result,
  input  logic                            cfg_wr_en,
  input  logic [psg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [psg_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);
  import psg_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_ACC  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t state;

  logic               gen_mode;
  logic               edge_or_level;
  logic [PHASE_W-1:0] start_phase;
  logic [31:0]        tick_seconds;
  logic [31:0]        ticks_per_second;
  logic [RATE_W-1:0]  default_rate_hz;
  logic               use_rate_input;

  logic [NEURON_W-1:0] neuron_q;
  logic [RATE_W-1:0]   rate_q;
  logic                trig_q;
  logic                en_q;
  logic                rst_q;
  logic [COUNT_W-1:0]  count_q;

  logic [RATE_W-1:0]    rate_sel;
  logic                 accept;
  psg_word_t            cur;
  psg_wr_t              mem_wr;
  logic [MUL_W-1:0]     mul_a;
  logic [MUL_W-1:0]     mul_b;
  logic [2*MUL_W-1:0]   mul_p;
  logic [2*MUL_W-1:0]   sum;
  logic [COUNT_W-1:0]   sat_count;
  logic [COUNT_W-1:0]   count_next;
  logic [RATE_W-1:0]    fire_sat;
  logic                 out_free;

  assign accept     = tick.valid && tick.ready;
  assign tick.ready = (state == S_IDLE);
  assign out_free   = !result.valid || result.ready;

  always_comb begin
    if (use_rate_input) begin
      rate_sel = tick.rate_hz[31] ? '0 : tick.rate_hz[RATE_W-1:0];
    end else begin
      rate_sel = default_rate_hz;
    end
  end

  psg_state_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (tick.neuron[ADDR_W-1:0]),
    .rd_word (cur),
    .wr      (mem_wr)
  );

  psg_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // phase add and count saturation
  assign sum       = mul_p + {{(2*MUL_W-PHASE_W-24){1'b0}}, cur.phase, 24'b0};
  assign sat_count = (|sum[63:48]) ? {COUNT_W{1'b1}} : sum[47:40];

  always_comb begin
    count_next       = '0;
    mem_wr.en        = (state == S_ACC);
    mem_wr.addr      = neuron_q[ADDR_W-1:0];
    mem_wr.word      = cur;
    if (rst_q) begin
      mem_wr.word.phase = start_phase;
      mem_wr.word.trig  = 1'b0;
    end else if (gen_mode == GEN_REGULAR) begin
      if (en_q) begin
        count_next        = sat_count;
        mem_wr.word.phase = sum[39:24];
      end
    end else begin
      mem_wr.word.trig = trig_q;
      if (en_q && trig_q) begin
        if (edge_or_level == TRIG_LEVEL || !cur.trig) begin
          count_next = COUNT_W'(1);
        end
      end
    end
  end

  always_comb begin
    if (state == S_RD) begin
      mul_a = {{(MUL_W-RATE_W){1'b0}}, rate_q};
      mul_b = tick_seconds;
    end else if (state == S_ACC) begin
      mul_a = {{(MUL_W-COUNT_W){1'b0}}, count_next};
      mul_b = ticks_per_second;
    end else begin
      mul_a = {{(MUL_W-COUNT_W){1'b0}}, count_q};
      mul_b = ticks_per_second;
    end
  end

  assign fire_sat = (|mul_p[63:31]) ? {RATE_W{1'b1}} : mul_p[30:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      result.valid     <= 1'b0;
      gen_mode         <= GEN_REGULAR;
      edge_or_level    <= TRIG_EDGE;
      start_phase      <= '0;
      tick_seconds     <= 32'd167772;
      ticks_per_second <= 32'd6553600;
      default_rate_hz  <= '0;
      use_rate_input   <= 1'b1;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_GEN_MODE:         gen_mode         <= cfg_wr_data[0];
          CFG_EDGE_OR_LEVEL:    edge_or_level    <= cfg_wr_data[0];
          CFG_START_PHASE:      start_phase      <= cfg_wr_data[PHASE_W-1:0];
          CFG_TICK_SECONDS:     tick_seconds     <= cfg_wr_data[31:0];
          CFG_TICKS_PER_SECOND: ticks_per_second <= cfg_wr_data[31:0];
          CFG_DEFAULT_RATE:     default_rate_hz  <= cfg_wr_data[RATE_W-1:0];
          CFG_USE_RATE_INPUT:   use_rate_input   <= cfg_wr_data[0];
          default: ;
        endcase
      end
      if (state == S_FIN && out_free) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_RD;
          end
        end
        S_RD:  state <= S_ACC;
        S_ACC: state <= S_FIN;
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      neuron_q <= tick.neuron;
      rate_q   <= rate_sel;
      trig_q   <= tick.trigger_high && tick.trigger_wired;
      en_q     <= tick.enabled;
      rst_q    <= tick.reset_request;
    end
    if (state == S_ACC) begin
      count_q <= count_next;
    end
    if (state == S_FIN && out_free) begin
      result.neuron_out        <= neuron_q;
      result.spike             <= |count_q;
      result.spike_total       <= count_q;
      result.firing_rate_hz    <= fire_sat;
      result.effective_rate_hz <= rate_q;
    end
  end

  a_accept_reads: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_RD)
    else $error("accepted word did not start a read");

  a_spike_matches_count: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.spike == (result.spike_total != '0))
    else $error("spike flag disagrees with count");

  a_zero_count_zero_rate: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.spike_total == '0) |-> result.firing_rate_hz == '0)
    else $error("firing rate nonzero with no spikes");

  a_fin_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && !result.valid) |=> (result.valid && state == S_IDLE))
    else $error("finished word not loaded into output register");

endmodule
